>>> src/wsfd_pkg.sv
// shared types and constants of the websocket frame deframer
// no dependencies; used by wsfd_parser and websocket_frame_deframer_unit
package wsfd_pkg;

    // result kinds
    localparam logic [1:0] KIND_HDR      = 2'd0;
    localparam logic [1:0] KIND_HDR_DONE = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd2;

    // header byte fields
    localparam logic [7:0] FIN_BIT    = 8'h80;
    localparam logic [7:0] OPCODE_MSK = 8'h0F;
    localparam logic [7:0] MASK_BIT   = 8'h80;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;

    // header bytes still to come minus one
    localparam logic [2:0] CNT_EXT16 = 3'd1;
    localparam logic [2:0] CNT_EXT64 = 3'd7;
    localparam logic [2:0] CNT_KEY   = 3'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic        frame_end;
    } t_result;

endpackage

>>> src/websocket_frame_deframer_unit.sv
// top level of the websocket receive-side frame deframer
// depends on wsfd_pkg and wsfd_parser
//
// usage:
//   input channel: one byte of the received connection stream per transfer
//   (i_in_valid, i_in_byte; the block drives o_in_stall)
//   output channel: exactly one result per input byte (o_out_valid and the
//   result fields; the receiver drives i_out_stall)
//   each result is a header byte taken, a header complete carrying fin,
//   opcode, mask flag and payload length, or an unmasked payload byte;
//   o_frame_end marks the last byte of a frame (a zero-length frame ends on
//   its header-completing byte)
// output timing: the result of an input transfer is registered and shows on the
//   output register in the cycle after the transfer
// throughput: one byte per cycle while the receiver does not stall; the frame
//   state update and the 64-bit offset increment/compare sit in the combinational
//   path between the frame state registers and the output register
// stall: o_in_stall rises only while a result is held and the receiver
//   stalls it; a byte taken in the same cycle as the held result leaves
//   replaces it in the output register
// reset: synchronous, active low; the parser expects the first header byte
//   of a frame and the output register is empty
module websocket_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_fin,
    output logic [3:0]  o_opcode,
    output logic        o_masked,
    output logic [63:0] o_payload_length,
    output logic        o_frame_end
);

    logic              in_take;
    logic              r_valid;
    wsfd_pkg::t_result res;
    wsfd_pkg::t_result r_res;

    // hold off input only while the output register is full and stuck
    assign o_in_stall = r_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;

    wsfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_byte  (i_in_byte),
        .o_res   (res)
    );

    // output valid: set by a new transfer in, cleared when the result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_take) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_kind           = r_res.kind;
    assign o_out_byte       = r_res.out_byte;
    assign o_fin            = r_res.fin;
    assign o_opcode         = r_res.opcode;
    assign o_masked         = r_res.masked;
    assign o_payload_length = r_res.payload_length;
    assign o_frame_end      = r_res.frame_end;

    // only the known result kinds come out
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == wsfd_pkg::KIND_HDR || o_kind == wsfd_pkg::KIND_HDR_DONE
                         || o_kind == wsfd_pkg::KIND_PAYLOAD))
        else $error("unknown result kind");

    // data byte is zero outside the payload
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != wsfd_pkg::KIND_PAYLOAD) |-> (o_out_byte == 8'd0))
        else $error("non-payload result carries data");

    // a frame never ends on a plain header byte
    a_no_end_mid_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == wsfd_pkg::KIND_HDR) |-> !o_frame_end)
        else $error("frame end on a partial header");

    // input is held off only while a result is stuck in the output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule

>>> src/wsfd_parser.sv
// frame header / payload parser: holds the frame state and computes one result per byte
// depends on wsfd_pkg
module wsfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output wsfd_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_count,  n_count;
    logic        r_fin,    n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask,   n_mask;
    logic [63:0] r_len,    n_len;
    logic [31:0] r_key,    n_key;
    logic [63:0] r_offset, n_offset;

    logic [63:0] offset_inc;
    logic [7:0]  key_byte;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        fend;

    assign offset_inc = r_offset + 64'd1;

    always_comb begin
        case (r_offset[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_fin    = r_fin;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_len    = r_len;
        n_key    = r_key;
        n_offset = r_offset;
        kind     = wsfd_pkg::KIND_HDR;
        data     = 8'd0;
        fend     = 1'b0;
        case (r_phase)
            PH_SECOND: begin
                n_mask = (i_byte & wsfd_pkg::MASK_BIT) != 8'd0;
                n_len  = 64'd0;
                if (i_byte[6:0] == wsfd_pkg::LEN_EXT16) begin
                    n_phase = PH_EXTLEN;
                    n_count = wsfd_pkg::CNT_EXT16;
                end else if (i_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
                    n_phase = PH_EXTLEN;
                    n_count = wsfd_pkg::CNT_EXT64;
                end else begin
                    n_len = {57'd0, i_byte[6:0]};
                    if (n_mask) begin
                        n_phase = PH_MASK;
                        n_count = wsfd_pkg::CNT_KEY;
                    end else begin
                        kind     = wsfd_pkg::KIND_HDR_DONE;
                        n_offset = 64'd0;
                        fend     = (i_byte[6:0] == 7'd0);
                        n_phase  = fend ? PH_FIRST : PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                n_len = {r_len[55:0], i_byte};
                if (r_count == 3'd0) begin
                    if (r_mask) begin
                        n_phase = PH_MASK;
                        n_count = wsfd_pkg::CNT_KEY;
                    end else begin
                        kind     = wsfd_pkg::KIND_HDR_DONE;
                        n_offset = 64'd0;
                        fend     = (n_len == 64'd0);
                        n_phase  = fend ? PH_FIRST : PH_PAYLOAD;
                    end
                end else begin
                    n_count = r_count - 3'd1;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], i_byte};
                if (r_count == 3'd0) begin
                    kind     = wsfd_pkg::KIND_HDR_DONE;
                    n_offset = 64'd0;
                    fend     = (r_len == 64'd0);
                    n_phase  = fend ? PH_FIRST : PH_PAYLOAD;
                end else begin
                    n_count = r_count - 3'd1;
                end
            end
            PH_PAYLOAD: begin
                kind     = wsfd_pkg::KIND_PAYLOAD;
                data     = r_mask ? (i_byte ^ key_byte) : i_byte;
                n_offset = offset_inc;
                if (offset_inc == r_len) begin
                    fend    = 1'b1;
                    n_phase = PH_FIRST;
                end
            end
            default: begin
                // first header byte; unused phase codes land here too
                n_fin    = (i_byte & wsfd_pkg::FIN_BIT) != 8'd0;
                n_opcode = 4'(i_byte & wsfd_pkg::OPCODE_MSK);
                n_mask   = 1'b0;
                n_len    = 64'd0;
                n_key    = 32'd0;
                n_offset = 64'd0;
                n_count  = 3'd0;
                n_phase  = PH_SECOND;
            end
        endcase
    end

    always_comb begin
        o_res.kind           = kind;
        o_res.out_byte       = data;
        o_res.fin            = n_fin;
        o_res.opcode         = n_opcode;
        o_res.masked         = n_mask;
        o_res.payload_length = n_len;
        o_res.frame_end      = fend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_count  <= 3'd0;
            r_fin    <= 1'b0;
            r_opcode <= 4'd0;
            r_mask   <= 1'b0;
            r_len    <= 64'd0;
            r_key    <= 32'd0;
            r_offset <= 64'd0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_len    <= n_len;
            r_key    <= n_key;
            r_offset <= n_offset;
        end
    end

endmodule
